>>> hdl/accel_orientation_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer orientation detector.
// Each macro checks a property on the rising edge of i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_ORIENTATION_DETECTOR_DEFINES_SVH
`define ACCEL_ORIENTATION_DETECTOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define AOD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define AOD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AOD_ASSERT_IMP(label, ante, cons)
`define AOD_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> hdl/aod_pkg.sv
// ----------------------------------------------------------------------------
// aod_pkg
// Types and constants shared by the orientation detector files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aod_pkg;

    // Sample width and the working width of the window and difference math.
    localparam int SAMPLE_WIDTH = 16;
    localparam int THRESH_W     = 16;
    localparam int LEVEL_W      = 15;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int WIN_W        = ((SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W) + 2;

    // Register reset values.
    localparam logic [THRESH_W-1:0] RST_CHANGE_THRESHOLD = 16'd400;
    localparam logic [LEVEL_W-1:0]  RST_ONE_G_LEVEL      = 15'd1000;
    localparam logic [LEVEL_W-1:0]  RST_FLAT_WINDOW      = 15'd20;
    localparam logic [LEVEL_W-1:0]  RST_NARROW_WINDOW    = 15'd200;
    localparam logic [LEVEL_W-1:0]  RST_WIDE_WINDOW      = 15'd500;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANGE_THRESHOLD = 3'd0,
        CFG_ONE_G_LEVEL      = 3'd1,
        CFG_FLAT_WINDOW      = 3'd2,
        CFG_NARROW_WINDOW    = 3'd3,
        CFG_WIDE_WINDOW      = 3'd4
    } t_cfg_idx;

    // Orientation classes.
    typedef enum logic [2:0] {
        ORIENT_NONE        = 3'd0,
        ORIENT_FLAT        = 3'd1,
        ORIENT_UPRIGHT     = 3'd2,
        ORIENT_RIGHT       = 3'd3,
        ORIENT_UPSIDE_DOWN = 3'd4,
        ORIENT_LEFT        = 3'd5
    } t_orient;

    // Screen rotation in quarter turns.
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rotation;

    typedef struct packed {
        logic [THRESH_W-1:0] change_threshold;
        logic [LEVEL_W-1:0]  one_g_level;
        logic [LEVEL_W-1:0]  flat_window;
        logic [LEVEL_W-1:0]  narrow_window;
        logic [LEVEL_W-1:0]  wide_window;
    } t_cfg;

    typedef struct packed {
        logic      changed;
        t_orient   orientation;
        logic      rotate_request;
        t_rotation rotation;
        logic      face_down;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/aod_ifs.sv
// ----------------------------------------------------------------------------
// Orientation detector channels
// Sample, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// One accelerometer sample per beat.
interface aod_in_if;
    import aod_pkg::*;
    logic    valid;
    logic    ready;
    t_sample accel_x;
    t_sample accel_y;
    t_sample accel_z;
    logic    packet_complete;

    modport source (output valid, accel_x, accel_y, accel_z, packet_complete, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, packet_complete, output ready);
endinterface

// One classification result per beat.
interface aod_out_if;
    logic       valid;
    logic       ready;
    logic       changed;
    logic [2:0] orientation;
    logic       rotate_request;
    logic [1:0] rotation;
    logic       face_down;

    modport source (output valid, changed, orientation, rotate_request, rotation, face_down,
                    input ready);
    modport sink   (input valid, changed, orientation, rotate_request, rotation, face_down,
                    output ready);
endinterface

// One register write per beat.
interface aod_cfg_if;
    import aod_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/accel_orientation_detector.sv
// ----------------------------------------------------------------------------
// accel_orientation_detector
// Path: an accepted sample beat is held in the input register, classified, and its result held in the result register.
// Throughput: one sample per cycle while the output is not stalled.
// Reset: synchronous active low; clears the reference, registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "accel_orientation_detector_defines.svh"

module accel_orientation_detector (
    input  wire        i_clk,
    input  wire        i_rst_n,
    aod_in_if.sink     i_in,
    aod_out_if.source  o_out,
    aod_cfg_if.sink    i_cfg
);
    import aod_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_valid;
    t_sample r_s1_x, r_s1_y, r_s1_z;
    t_sample r_ref_x, r_ref_y, r_ref_z;
    logic    r_primed;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    in_acc;
    logic    s1_adv;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.change_threshold <= RST_CHANGE_THRESHOLD;
            r_cfg.one_g_level      <= RST_ONE_G_LEVEL;
            r_cfg.flat_window      <= RST_FLAT_WINDOW;
            r_cfg.narrow_window    <= RST_NARROW_WINDOW;
            r_cfg.wide_window      <= RST_WIDE_WINDOW;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CHANGE_THRESHOLD: r_cfg.change_threshold <= i_cfg.data;
                CFG_ONE_G_LEVEL:      r_cfg.one_g_level      <= i_cfg.data[LEVEL_W-1:0];
                CFG_FLAT_WINDOW:      r_cfg.flat_window      <= i_cfg.data[LEVEL_W-1:0];
                CFG_NARROW_WINDOW:    r_cfg.narrow_window    <= i_cfg.data[LEVEL_W-1:0];
                CFG_WIDE_WINDOW:      r_cfg.wide_window      <= i_cfg.data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // The input stage moves on when its beat makes no result or the output slot frees up.
    assign s1_adv     = r_s1_valid && (!r_primed || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    // Input register; incomplete packets never enter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= i_in.packet_complete;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x <= i_in.accel_x;
            r_s1_y <= i_in.accel_y;
            r_s1_z <= i_in.accel_z;
        end
    end

    // Every complete sample becomes the new reference as it leaves the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x  <= '0;
            r_ref_y  <= '0;
            r_ref_z  <= '0;
            r_primed <= 1'b0;
        end else if (s1_adv) begin
            r_ref_x  <= r_s1_x;
            r_ref_y  <= r_s1_y;
            r_ref_z  <= r_s1_z;
            r_primed <= 1'b1;
        end
    end

    aod_classify u_classify (
        .i_x      (r_s1_x),
        .i_y      (r_s1_y),
        .i_z      (r_s1_z),
        .i_ref_x  (r_ref_x),
        .i_ref_y  (r_ref_y),
        .i_ref_z  (r_ref_z),
        .i_cfg    (r_cfg),
        .o_result (n_out)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_primed) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_primed) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.changed        = r_out.changed;
    assign o_out.orientation    = r_out.orientation;
    assign o_out.rotate_request = r_out.rotate_request;
    assign o_out.rotation       = r_out.rotation;
    assign o_out.face_down      = r_out.face_down;

    // An unchanged sample carries no class, request or face-down flag.
    `AOD_ASSERT_IMP(a_quiet_unchanged, r_out_valid && !r_out.changed,
        r_out.orientation == ORIENT_NONE && !r_out.rotate_request && !r_out.face_down)
    // A rotation request goes with a class and only with one.
    `AOD_ASSERT_IMP(a_request_class, r_out_valid,
        r_out.rotate_request == (r_out.orientation != ORIENT_NONE))
    // After any sample leaves the input stage a reference is stored.
    `AOD_ASSERT_NXT(a_primed_after, s1_adv, r_primed)
    // A new beat never lands on an input stage that is still held.
    `AOD_ASSERT_IMP(a_no_overwrite, in_acc && r_s1_valid, s1_adv)

endmodule

`default_nettype wire

>>> hdl/aod_classify.sv
// ----------------------------------------------------------------------------
// aod_classify
// Change detection against the reference and orientation classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aod_classify (
    input  var aod_pkg::t_sample i_x,
    input  var aod_pkg::t_sample i_y,
    input  var aod_pkg::t_sample i_z,
    input  var aod_pkg::t_sample i_ref_x,
    input  var aod_pkg::t_sample i_ref_y,
    input  var aod_pkg::t_sample i_ref_z,
    input  var aod_pkg::t_cfg    i_cfg,
    output aod_pkg::t_result     o_result
);
    import aod_pkg::*;

    typedef logic signed [WIN_W-1:0] t_wide;

    // True when target - half < v <= target + half.
    function automatic logic in_win(input t_wide v, input t_wide target,
                                    input logic [LEVEL_W-1:0] half);
        t_wide w;
        w = signed'(WIN_W'(half));
        return ((target - w) < v) && (v <= (target + w));
    endfunction

    // Absolute difference of two samples, as a non-negative wide value.
    function automatic t_wide abs_diff(input t_sample a, input t_sample b);
        t_wide d;
        d = WIN_W'(a) - WIN_W'(b);
        return (d < 0) ? -d : d;
    endfunction

    t_wide x, y, z, g_pos, g_neg, th;
    logic  changed;

    assign x     = WIN_W'(i_x);
    assign y     = WIN_W'(i_y);
    assign z     = WIN_W'(i_z);
    assign g_pos = signed'(WIN_W'(i_cfg.one_g_level));
    assign g_neg = -g_pos;
    assign th    = signed'(WIN_W'(i_cfg.change_threshold));

    assign changed = (abs_diff(i_ref_x, i_x) >= th) || (abs_diff(i_ref_y, i_y) >= th) ||
                     (abs_diff(i_ref_z, i_z) >= th);

    // Classes are tested in order; a later match overrides an earlier one.
    always_comb begin
        o_result = '0;
        o_result.orientation = ORIENT_NONE;
        o_result.rotation    = ROT_0;
        if (changed) begin
            o_result.changed   = 1'b1;
            o_result.face_down = (z < 0);
            if (z > x && z > y && in_win(x, '0, i_cfg.flat_window) &&
                in_win(z, g_pos, i_cfg.narrow_window)) begin
                o_result.orientation    = ORIENT_FLAT;
                o_result.rotation       = ROT_0;
                o_result.rotate_request = 1'b1;
            end
            if (y < x && y < z && in_win(y, g_neg, i_cfg.narrow_window)) begin
                o_result.orientation    = ORIENT_UPRIGHT;
                o_result.rotation       = ROT_0;
                o_result.rotate_request = 1'b1;
            end
            if (x > y && x > z && in_win(x, g_pos, i_cfg.wide_window)) begin
                o_result.orientation    = ORIENT_RIGHT;
                o_result.rotation       = ROT_90;
                o_result.rotate_request = 1'b1;
            end
            if (y > x && y > z && in_win(y, g_pos, i_cfg.narrow_window)) begin
                o_result.orientation    = ORIENT_UPSIDE_DOWN;
                o_result.rotation       = ROT_180;
                o_result.rotate_request = 1'b1;
            end
            if (x < y && x < z && in_win(x, g_neg, i_cfg.wide_window)) begin
                o_result.orientation    = ORIENT_LEFT;
                o_result.rotation       = ROT_270;
                o_result.rotate_request = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Orientation detector testbench
// Drives accelerometer beats with random gaps and output stalls, tracks the
// stored reference and register values in a class, and checks every report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import aod_pkg::*;

    // Run limits: cycles after the last report, and an overall cycle cap.
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SEG_ITEMS    = 238;

    // One sample beat as the sender sees it.
    typedef struct {
        t_sample x;
        t_sample y;
        t_sample z;
        bit      complete;
    } t_accel_beat;

    // Tracks the reference sample and registers, and holds the reports due.
    class orientation_tracker;
        logic [THRESH_W-1:0] min_delta;
        logic [LEVEL_W-1:0]  one_g;
        logic [LEVEL_W-1:0]  flat_half;
        logic [LEVEL_W-1:0]  narrow_half;
        logic [LEVEL_W-1:0]  wide_half;
        t_sample             last_x;
        t_sample             last_y;
        t_sample             last_z;
        bit                  has_reference;
        t_result             reports_due[$];
        int unsigned         mismatches;
        int unsigned         reports_seen;
        int unsigned         changes_due;
        int unsigned         requests_due;

        function new();
            min_delta     = RST_CHANGE_THRESHOLD;
            one_g         = RST_ONE_G_LEVEL;
            flat_half     = RST_FLAT_WINDOW;
            narrow_half   = RST_NARROW_WINDOW;
            wide_half     = RST_WIDE_WINDOW;
            last_x        = '0;
            last_y        = '0;
            last_z        = '0;
            has_reference = 1'b0;
            mismatches    = 0;
            reports_seen  = 0;
            changes_due   = 0;
            requests_due  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_CHANGE_THRESHOLD: min_delta   = value;
                CFG_ONE_G_LEVEL:      one_g       = value[LEVEL_W-1:0];
                CFG_FLAT_WINDOW:      flat_half   = value[LEVEL_W-1:0];
                CFG_NARROW_WINDOW:    narrow_half = value[LEVEL_W-1:0];
                CFG_WIDE_WINDOW:      wide_half   = value[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // The window is open at the bottom and closed at the top.
        function bit in_window(int v, int center, int half);
            return (center - half < v) && (v <= center + half);
        endfunction

        function int distance(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Classifies one accepted beat and queues the report it causes.
        function void take_sample(t_sample x, t_sample y, t_sample z, bit complete);
            t_result rep;
            int      xi;
            int      yi;
            int      zi;
            int      g;
            int      th;
            if (!complete)
                return;
            if (!has_reference) begin
                last_x        = x;
                last_y        = y;
                last_z        = z;
                has_reference = 1'b1;
                return;
            end
            xi  = x;
            yi  = y;
            zi  = z;
            g   = int'(one_g);
            th  = int'(min_delta);
            rep = '0;
            if (distance(xi, int'(last_x)) >= th || distance(yi, int'(last_y)) >= th ||
                distance(zi, int'(last_z)) >= th) begin
                rep.changed = 1'b1;
                // Later classes override earlier ones when several match.
                if (zi > xi && zi > yi && in_window(xi, 0, int'(flat_half)) &&
                    in_window(zi, g, int'(narrow_half))) begin
                    rep.orientation    = ORIENT_FLAT;
                    rep.rotation       = ROT_0;
                    rep.rotate_request = 1'b1;
                end
                if (yi < xi && yi < zi && in_window(yi, -g, int'(narrow_half))) begin
                    rep.orientation    = ORIENT_UPRIGHT;
                    rep.rotation       = ROT_0;
                    rep.rotate_request = 1'b1;
                end
                if (xi > yi && xi > zi && in_window(xi, g, int'(wide_half))) begin
                    rep.orientation    = ORIENT_RIGHT;
                    rep.rotation       = ROT_90;
                    rep.rotate_request = 1'b1;
                end
                if (yi > xi && yi > zi && in_window(yi, g, int'(narrow_half))) begin
                    rep.orientation    = ORIENT_UPSIDE_DOWN;
                    rep.rotation       = ROT_180;
                    rep.rotate_request = 1'b1;
                end
                if (xi < yi && xi < zi && in_window(xi, -g, int'(wide_half))) begin
                    rep.orientation    = ORIENT_LEFT;
                    rep.rotation       = ROT_270;
                    rep.rotate_request = 1'b1;
                end
                rep.face_down = (zi < 0);
                changes_due++;
                if (rep.rotate_request)
                    requests_due++;
            end
            last_x = x;
            last_y = y;
            last_z = z;
            reports_due.push_back(rep);
        endfunction

        function void compare_field(string name, logic [2:0] want, logic [2:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Checks one accepted report against the oldest one due.
        function void check_report(logic changed, logic [2:0] orient, logic request,
                                   logic [1:0] rot, logic down);
            t_result want;
            reports_seen++;
            if (reports_due.size() == 0) begin
                $error("report beat arrived with no report due");
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            compare_field("changed", 3'(want.changed), 3'(changed));
            compare_field("orientation", want.orientation, orient);
            compare_field("rotate_request", 3'(want.rotate_request), 3'(request));
            compare_field("rotation", 3'(want.rotation), 3'(rot));
            compare_field("face_down", 3'(want.face_down), 3'(down));
        endfunction

        function void flag_leftovers();
            if (reports_due.size() != 0) begin
                $error("%0d reports never arrived", reports_due.size());
                mismatches++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int unsigned        cycle_count;
    int unsigned        beats_sent;
    int unsigned        beats_ignored;
    orientation_tracker tracker;

    aod_in_if  in_ch ();
    aod_out_if out_ch ();
    aod_cfg_if cfg_ch ();

    accel_orientation_detector i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Output backpressure at the current stall rate.
    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Report beats are checked as they are accepted.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_report(out_ch.changed, out_ch.orientation, out_ch.rotate_request,
                                 out_ch.rotation, out_ch.face_down);
    end

    // Overall cycle cap.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_accel_beat beat(int x, int y, int z, bit complete);
        t_accel_beat b;
        b.x        = t_sample'(x);
        b.y        = t_sample'(y);
        b.z        = t_sample'(z);
        b.complete = complete;
        return b;
    endfunction

    // Picks a value on or next to a window boundary, or inside the window.
    function automatic int near_edge(int center, int half);
        case ($urandom_range(4))
            0: return center - half;
            1: return center - half + 1;
            2: return center + half;
            3: return center + half + 1;
            default: return center + int'($urandom_range(2 * half)) - half;
        endcase
    endfunction

    function automatic int corner_value();
        case ($urandom_range(3))
            0: return -32768;
            1: return -1;
            2: return 0;
            default: return 32767;
        endcase
    endfunction

    // Random beat: mostly aimed at a class window or the change threshold.
    function automatic t_accel_beat make_beat();
        int x;
        int y;
        int z;
        int g;
        int step;
        int pick;
        bit complete;
        g        = int'(tracker.one_g);
        x        = int'($urandom_range(600)) - 300;
        y        = int'($urandom_range(600)) - 300;
        z        = int'($urandom_range(600)) - 300;
        complete = 1'b1;
        pick     = $urandom_range(99);
        if (pick < 8) begin
            x        = $urandom;
            y        = $urandom;
            z        = $urandom;
            complete = 1'b0;
        end else if (pick < 20) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
        end else if (pick < 28) begin
            x = corner_value();
            y = corner_value();
            z = corner_value();
        end else if (pick < 45) begin
            // Move one axis by the threshold or one less from the reference.
            step = int'(tracker.min_delta) - int'($urandom_range(1));
            if ($urandom_range(1))
                step = -step;
            x = int'(tracker.last_x);
            y = int'(tracker.last_y);
            z = int'(tracker.last_z);
            case ($urandom_range(2))
                0: x = x + step;
                1: y = y + step;
                default: z = z + step;
            endcase
        end else begin
            case ($urandom_range(4))
                0: begin
                    x = near_edge(0, int'(tracker.flat_half));
                    z = near_edge(g, int'(tracker.narrow_half));
                end
                1: y = near_edge(-g, int'(tracker.narrow_half));
                2: x = near_edge(g, int'(tracker.wide_half));
                3: y = near_edge(g, int'(tracker.narrow_half));
                default: x = near_edge(-g, int'(tracker.wide_half));
            endcase
        end
        return beat(x, y, z, complete);
    endfunction

    function automatic t_cfg cfg_of(int th, int g, int flat, int narrow, int wide);
        t_cfg c;
        c.change_threshold = THRESH_W'(th);
        c.one_g_level      = LEVEL_W'(g);
        c.flat_window      = LEVEL_W'(flat);
        c.narrow_window    = LEVEL_W'(narrow);
        c.wide_window      = LEVEL_W'(wide);
        return c;
    endfunction

    // Sends one sample beat after a random gap and notes it once accepted.
    task automatic send_beat(t_accel_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid           <= 1'b0;
            in_ch.accel_x         <= t_sample'($urandom);
            in_ch.packet_complete <= 1'($urandom_range(1));
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.accel_x         <= b.x;
        in_ch.accel_y         <= b.y;
        in_ch.accel_z         <= b.z;
        in_ch.packet_complete <= b.complete;
        do @(posedge clk); while (!in_ch.ready);
        tracker.take_sample(b.x, b.y, b.z, b.complete);
        beats_sent++;
        if (!b.complete)
            beats_ignored++;
    endtask

    // Holds the sender until every report is in and the pipeline is empty.
    task automatic drain_reports();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.set_reg(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(t_cfg c);
        write_reg(CFG_CHANGE_THRESHOLD, c.change_threshold);
        write_reg(CFG_ONE_G_LEVEL, CFG_DATA_W'(c.one_g_level));
        write_reg(CFG_FLAT_WINDOW, CFG_DATA_W'(c.flat_window));
        write_reg(CFG_NARROW_WINDOW, CFG_DATA_W'(c.narrow_window));
        write_reg(CFG_WIDE_WINDOW, CFG_DATA_W'(c.wide_window));
    endtask

    // One random segment at the given gap and stall rates.
    task automatic run_segment(int send_pct, int recv_pct);
        t_accel_beat b;
        int          counted;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted       = 0;
        while (counted < SEG_ITEMS) begin
            b = make_beat();
            send_beat(b);
            counted++;
            if ($urandom_range(149) == 0)
                drain_reports();
        end
        drain_reports();
    endtask

    // Main sequence.
    initial begin
        tracker               = new();
        rst_n                 = 1'b0;
        cycle_count           = 0;
        beats_sent            = 0;
        beats_ignored         = 0;
        send_idle_pct         = 18;
        recv_idle_pct         = 81;
        in_ch.valid           = 1'b0;
        in_ch.accel_x         = '0;
        in_ch.accel_y         = '0;
        in_ch.accel_z         = '0;
        in_ch.packet_complete = 1'b0;
        out_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_CHANGE_THRESHOLD;
        cfg_ch.data           = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset register values.
        send_beat(beat(123, -5, 7, 1'b0));              // ignored before a reference
        send_beat(beat(0, 0, 0, 1'b1));                 // becomes the reference
        send_beat(beat(0, 0, 1000, 1'b1));              // flat
        send_beat(beat(0, -1000, 0, 1'b1));             // upright
        send_beat(beat(1000, 0, 0, 1'b1));              // right
        send_beat(beat(0, 1000, 0, 1'b1));              // upside down
        send_beat(beat(-1000, 0, 0, 1'b1));             // left
        send_beat(beat(0, 0, -1000, 1'b1));             // changed, no class, face down
        send_beat(beat(0, 0, -1000, 1'b1));             // no change
        send_beat(beat(32767, 32767, 32767, 1'b0));     // ignored, reference kept
        send_beat(beat(0, 0, -601, 1'b1));              // one below the threshold
        send_beat(beat(0, 0, -201, 1'b1));              // exactly at the threshold
        send_beat(beat(0, -1000, 1000, 1'b1));          // flat and upright match
        send_beat(beat(1000, -1000, 0, 1'b1));          // upright and right match
        send_beat(beat(-1000, 1000, 0, 1'b1));          // upside down and left match
        send_beat(beat(20, 0, 1200, 1'b1));             // flat on the closed edges
        send_beat(beat(-20, 0, 800, 1'b1));             // just outside the open edges
        send_beat(beat(-32768, -32768, -32768, 1'b1));
        send_beat(beat(32767, 32767, 32767, 1'b1));
        send_beat(beat(32767, -32768, 0, 1'b1));
        send_beat(beat(-32768, 32767, -1, 1'b1));
        send_beat(beat(0, 0, 0, 1'b1));
        drain_reports();

        // Random segments over several register settings and idle patterns.
        run_segment(18, 81);
        apply_setting(cfg_of(0, 0, 0, 0, 0));
        run_segment(18, 81);
        apply_setting(cfg_of(65535, 32767, 32767, 32767, 32767));
        run_segment(81, 18);
        apply_setting(cfg_of(1, 16384, 1, 1, 1));
        run_segment(81, 18);
        apply_setting(cfg_of($urandom_range(2000), $urandom_range(4000), $urandom_range(100),
                             $urandom_range(600), $urandom_range(1500)));
        run_segment(0, 0);
        apply_setting(cfg_of(300, 1000, 60, 250, 600));
        run_segment(0, 0);

        tracker.flag_leftovers();
        $display("Sent %0d sample beats (%0d incomplete) over six register settings.",
                 beats_sent, beats_ignored);
        $display("Checked %0d reports: %0d with a change, %0d with a rotation request.",
                 tracker.reports_seen, tracker.changes_due, tracker.requests_due);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/aod_pkg.sv
hdl/aod_ifs.sv
hdl/aod_classify.sv
hdl/accel_orientation_detector.sv
sim/testbench.sv
